@@ rtl/ctb_pkg.sv @@
// ----------------------------------------------------------------------------
// ctb_pkg
// shared types and constants for the countdown timer bank
// ----------------------------------------------------------------------------
package ctb_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int NUM_TIMERS  = 16;
  localparam int COUNT_WIDTH = 16;

  localparam int SLOT_AW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int TIMER_AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // payload field widths
  localparam int MODE_W  = 2;
  localparam int ID_W    = 4;
  localparam int TICKS_W = 16;

  typedef enum logic [MODE_W-1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK_SCAN,
    S_TICK_UPD,
    S_READ_WAIT,
    S_FREE_SCAN,
    S_STOP_SCAN,
    S_DONE
  } state_t;

endpackage

@@ rtl/countdown_timer_bank_top.sv @@
// ----------------------------------------------------------------------------
// countdown_timer_bank_top
// bank of countdown timers sharing a small table of running slots
// ----------------------------------------------------------------------------
// Each input transfer carries one operation (tick, start, stop, query) and
// produces exactly one result transfer with success and elapsed flags. The
// block handles one operation at a time: in_tready is high only while the
// sequencer is idle, and a finished result sits in the output register so the
// next operation can be taken while the result waits. The sequencer walks the
// slot table one slot per cycle, pausing on each running slot during a tick
// to read and write back its count, and the count memory has registered read
// data. A tick visits every slot; a start reads the count, loads it and, if
// the timer was idle, searches for a free slot; a stop searches for the slot
// of its timer; a query reads the count; an operation naming a timer outside
// the bank goes straight to its result. A result still waiting in the output
// register holds back the handover of the next result. in_tready returns in
// the cycle after the result is handed over. All counts and the slot table
// are clear after reset with no clearing pass.
// ----------------------------------------------------------------------------
module countdown_timer_bank_top (
  input  logic       clk,
  input  logic       rst_n,
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [23:0] in_tdata,   // [3:0] timer_id, [19:4] ticks, [23:20] zero
  input  logic [1:0]  in_tuser,   // [1:0] mode
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata    // [0] success, [1] elapsed, [7:2] zero
);

  localparam int CW  = ctb_pkg::COUNT_WIDTH;
  localparam int SAW = ctb_pkg::SLOT_AW;
  localparam int TAW = ctb_pkg::TIMER_AW;

  // input field split
  logic [ctb_pkg::ID_W-1:0]    in_id;
  logic [ctb_pkg::TICKS_W-1:0] in_ticks;
  ctb_pkg::op_t                in_op;
  logic                        in_xfer;
  logic                        in_id_ok;

  assign in_id    = in_tdata[3:0];
  assign in_ticks = in_tdata[19:4];
  assign in_op    = ctb_pkg::op_t'(in_tuser);
  assign in_xfer  = in_tvalid && in_tready;
  assign in_id_ok = (int'(in_id) < ctb_pkg::NUM_TIMERS);

  // sequencer state
  ctb_pkg::state_t state_r, state_nxt;
  logic [SAW-1:0]  slot_r, slot_nxt;
  ctb_pkg::op_t    op_r;
  logic [TAW-1:0]  id_r;
  logic [CW-1:0]   load_r;
  logic            res_success_r, res_success_nxt;
  logic            res_elapsed_r, res_elapsed_nxt;
  logic            slot_last;

  // slot table: valid bits in flops, owners in a small register array
  logic [ctb_pkg::NUM_SLOTS-1:0] slot_vld_r, slot_vld_nxt;
  logic [TAW-1:0]                slot_owner_r [ctb_pkg::NUM_SLOTS];
  logic                          owner_we;
  logic [TAW-1:0]                cur_owner;

  // count memory, one write and one read port, registered read data
  logic [CW-1:0]                  cnt_mem [ctb_pkg::NUM_TIMERS];
  logic [ctb_pkg::NUM_TIMERS-1:0] cnt_vld_r;
  logic [CW-1:0]                  cnt_rd_r;
  logic                           mem_we, mem_re;
  logic [TAW-1:0]                 mem_wa, mem_ra;
  logic [CW-1:0]                  mem_wd;
  logic [CW-1:0]                  cnt_dec;

  // output register
  logic out_tvalid_r, out_tvalid_nxt;
  logic out_success_r, out_success_nxt;
  logic out_elapsed_r, out_elapsed_nxt;

  assign in_tready  = (state_r == ctb_pkg::S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'd0, out_elapsed_r, out_success_r};

  assign slot_last = (slot_r == SAW'(ctb_pkg::NUM_SLOTS - 1));
  assign cur_owner = slot_owner_r[slot_r];
  // shared decrement, wraps from zero to all ones
  assign cnt_dec   = cnt_rd_r - CW'(1);

  // next state and datapath control
  always_comb begin
    state_nxt       = state_r;
    slot_nxt        = slot_r;
    res_success_nxt = res_success_r;
    res_elapsed_nxt = res_elapsed_r;
    slot_vld_nxt    = slot_vld_r;
    owner_we        = 1'b0;
    mem_we          = 1'b0;
    mem_wa          = id_r;
    mem_wd          = load_r;
    mem_re          = 1'b0;
    mem_ra          = id_r;
    out_tvalid_nxt  = out_tvalid_r;
    out_success_nxt = out_success_r;
    out_elapsed_nxt = out_elapsed_r;

    // result leaves the output register
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ctb_pkg::S_IDLE: begin
        if (in_xfer) begin
          slot_nxt        = '0;
          res_success_nxt = 1'b1;
          res_elapsed_nxt = 1'b0;
          mem_ra          = in_id[TAW-1:0];
          case (in_op)
            ctb_pkg::OP_TICK: begin
              state_nxt = ctb_pkg::S_TICK_SCAN;
            end
            ctb_pkg::OP_START: begin
              if (in_id_ok) begin
                mem_re    = 1'b1;
                state_nxt = ctb_pkg::S_READ_WAIT;
              end else begin
                res_success_nxt = 1'b0;
                state_nxt       = ctb_pkg::S_DONE;
              end
            end
            ctb_pkg::OP_STOP: begin
              if (in_id_ok) begin
                state_nxt = ctb_pkg::S_STOP_SCAN;
              end else begin
                res_success_nxt = 1'b0;
                state_nxt       = ctb_pkg::S_DONE;
              end
            end
            default: begin
              // query; a timer outside the bank reads as elapsed
              if (in_id_ok) begin
                mem_re    = 1'b1;
                state_nxt = ctb_pkg::S_READ_WAIT;
              end else begin
                res_elapsed_nxt = 1'b1;
                state_nxt       = ctb_pkg::S_DONE;
              end
            end
          endcase
        end
      end

      ctb_pkg::S_TICK_SCAN: begin
        if (slot_vld_r[slot_r]) begin
          mem_re    = 1'b1;
          mem_ra    = cur_owner;
          state_nxt = ctb_pkg::S_TICK_UPD;
        end else if (slot_last) begin
          state_nxt = ctb_pkg::S_DONE;
        end else begin
          slot_nxt = slot_r + SAW'(1);
        end
      end

      ctb_pkg::S_TICK_UPD: begin
        mem_we = 1'b1;
        mem_wa = cur_owner;
        mem_wd = cnt_dec;
        if (cnt_dec == '0) begin
          slot_vld_nxt[slot_r] = 1'b0;
        end
        if (slot_last) begin
          state_nxt = ctb_pkg::S_DONE;
        end else begin
          slot_nxt  = slot_r + SAW'(1);
          state_nxt = ctb_pkg::S_TICK_SCAN;
        end
      end

      ctb_pkg::S_READ_WAIT: begin
        if (op_r == ctb_pkg::OP_QUERY) begin
          res_elapsed_nxt = (cnt_rd_r == '0);
          state_nxt       = ctb_pkg::S_DONE;
        end else begin
          // start always loads; a running timer needs no slot
          mem_we = 1'b1;
          if (cnt_rd_r != '0) begin
            state_nxt = ctb_pkg::S_DONE;
          end else begin
            state_nxt = ctb_pkg::S_FREE_SCAN;
          end
        end
      end

      ctb_pkg::S_FREE_SCAN: begin
        if (!slot_vld_r[slot_r]) begin
          slot_vld_nxt[slot_r] = 1'b1;
          owner_we             = 1'b1;
          state_nxt            = ctb_pkg::S_DONE;
        end else if (slot_last) begin
          res_success_nxt = 1'b0;
          state_nxt       = ctb_pkg::S_DONE;
        end else begin
          slot_nxt = slot_r + SAW'(1);
        end
      end

      ctb_pkg::S_STOP_SCAN: begin
        if (slot_vld_r[slot_r] && (cur_owner == id_r)) begin
          slot_vld_nxt[slot_r] = 1'b0;
          mem_we               = 1'b1;
          mem_wd               = '0;
          state_nxt            = ctb_pkg::S_DONE;
        end else if (slot_last) begin
          res_success_nxt = 1'b0;
          state_nxt       = ctb_pkg::S_DONE;
        end else begin
          slot_nxt = slot_r + SAW'(1);
        end
      end

      ctb_pkg::S_DONE: begin
        // wait for room in the output register
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt  = 1'b1;
          out_success_nxt = res_success_r;
          out_elapsed_nxt = res_elapsed_r;
          state_nxt       = ctb_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ctb_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ctb_pkg::S_IDLE;
      slot_vld_r   <= '0;
      cnt_vld_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_vld_r   <= slot_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (mem_we) begin
        cnt_vld_r[mem_wa] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    slot_r        <= slot_nxt;
    res_success_r <= res_success_nxt;
    res_elapsed_r <= res_elapsed_nxt;
    out_success_r <= out_success_nxt;
    out_elapsed_r <= out_elapsed_nxt;
    if (in_xfer) begin
      op_r   <= in_op;
      id_r   <= in_id[TAW-1:0];
      load_r <= CW'(in_ticks);
    end
    if (owner_we) begin
      slot_owner_r[slot_r] <= id_r;
    end
  end

  // count memory; entries never written read as zero
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      cnt_rd_r <= cnt_vld_r[mem_ra] ? cnt_mem[mem_ra] : '0;
    end
  end

`ifndef NO_ASSERTIONS
  // an accepted operation always starts the sequencer
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != ctb_pkg::S_IDLE))
    else $error("sequencer idle after input transfer");

  // elapsed is only reported for query
  a_elapsed_query: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ctb_pkg::S_DONE && res_elapsed_r) |-> (op_r == ctb_pkg::OP_QUERY))
    else $error("elapsed set on non-query operation");

  // tick never fails
  a_tick_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ctb_pkg::S_DONE && op_r == ctb_pkg::OP_TICK) |-> res_success_r)
    else $error("tick reported failure");

  // a free slot found by start is taken
  a_slot_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ctb_pkg::S_FREE_SCAN && !slot_vld_r[slot_r]) |=>
      slot_vld_r[$past(slot_r)])
    else $error("free slot not claimed");
`endif

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench for the countdown timer bank
// ----------------------------------------------------------------------------
// Drives tick, start, stop and query operations into the input stream and
// checks every result transfer against an in-bench model of the count store
// and slot table. A short table of directed operations covers reset state,
// count extremes, slot exhaustion, restarts, repeated slots and stops of idle
// timers. Random operations follow, biased toward a few timers with short
// counts so that slots fill, expire and get reused. Both stream sides idle
// at random in phases one and two, the receiver holds off once for a long
// stretch, and the sender drains all pending results at phase boundaries.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int TAIL_CYCLES = 30;    // worst tick latency plus margin
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_ITEMS = 642;   // random operations per phase

  // result flags, same order as out_tdata
  typedef struct packed {
    logic elapsed;
    logic success;
  } tmr_flags_t;

  // one directed operation, with the result typed in where it is obvious
  typedef struct {
    ctb_pkg::op_t                op;
    logic [ctb_pkg::ID_W-1:0]    id;
    logic [ctb_pkg::TICKS_W-1:0] tk;
    bit                          typed;
    logic                        success;
    logic                        elapsed;
  } dir_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;

  // idling knobs, percent of cycles spent idle
  int unsigned send_idle_pct = 30;
  int unsigned recv_idle_pct = 52;
  bit          hold_req      = 1'b0;
  bit          hold_done     = 1'b0;
  int          hold_left     = 0;

  int unsigned cycle_cnt   = 0;
  int unsigned fail_cnt    = 0;
  int unsigned checked_cnt = 0;
  int unsigned op_cnt [4]  = '{default: 0};
  int unsigned start_fails = 0;
  int unsigned elapsed_hits = 0;

  // model state: counts per timer, slot owner and busy flag per slot
  logic [ctb_pkg::COUNT_WIDTH-1:0] run_count [ctb_pkg::NUM_TIMERS] = '{default: '0};
  logic [ctb_pkg::ID_W-1:0]        slot_tmr  [ctb_pkg::NUM_SLOTS]  = '{default: '0};
  logic                            slot_busy [ctb_pkg::NUM_SLOTS]  = '{default: 1'b0};

  // results still owed by the block, oldest first
  tmr_flags_t flags_due [$];

  // directed operations
  dir_row_t dir_rows [25] = '{
    // query and tick straight out of reset
    '{ctb_pkg::OP_QUERY, 4'd0,  16'h0000, 1'b1, 1'b1, 1'b1},
    '{ctb_pkg::OP_TICK,  4'd9,  16'hFFFF, 1'b1, 1'b1, 1'b0},
    // stop of a timer that holds no slot
    '{ctb_pkg::OP_STOP,  4'd3,  16'h0000, 1'b1, 1'b0, 1'b0},
    // largest count on the lowest timer, zero count on the highest
    '{ctb_pkg::OP_START, 4'd0,  16'hFFFF, 1'b1, 1'b1, 1'b0},
    '{ctb_pkg::OP_START, 4'd15, 16'h0000, 1'b1, 1'b1, 1'b0},
    // zero count again: second slot for the same timer
    '{ctb_pkg::OP_START, 4'd15, 16'h0000, 1'b0, 1'b0, 1'b0},
    // timer 15 wraps and is decremented once per slot
    '{ctb_pkg::OP_TICK,  4'd0,  16'h0000, 1'b0, 1'b0, 1'b0},
    '{ctb_pkg::OP_QUERY, 4'd15, 16'h0000, 1'b0, 1'b0, 1'b0},
    // restart of a running timer
    '{ctb_pkg::OP_START, 4'd0,  16'h0002, 1'b0, 1'b0, 1'b0},
    // fill the remaining slots
    '{ctb_pkg::OP_START, 4'd1,  16'h0001, 1'b0, 1'b0, 1'b0},
    '{ctb_pkg::OP_START, 4'd2,  16'h0002, 1'b0, 1'b0, 1'b0},
    '{ctb_pkg::OP_START, 4'd3,  16'h0003, 1'b0, 1'b0, 1'b0},
    '{ctb_pkg::OP_START, 4'd4,  16'h0004, 1'b0, 1'b0, 1'b0},
    '{ctb_pkg::OP_START, 4'd5,  16'h0005, 1'b0, 1'b0, 1'b0},
    // table full: count loads, start fails
    '{ctb_pkg::OP_START, 4'd6,  16'h8000, 1'b0, 1'b0, 1'b0},
    // reload of a slotless timer with a nonzero count
    '{ctb_pkg::OP_START, 4'd6,  16'h0003, 1'b0, 1'b0, 1'b0},
    '{ctb_pkg::OP_STOP,  4'd6,  16'h0000, 1'b0, 1'b0, 1'b0},
    // timer 1 expires and frees its slot
    '{ctb_pkg::OP_TICK,  4'd0,  16'h0000, 1'b0, 1'b0, 1'b0},
    // stop frees only the lowest of timer 15's slots
    '{ctb_pkg::OP_STOP,  4'd15, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{ctb_pkg::OP_QUERY, 4'd0,  16'h0000, 1'b0, 1'b0, 1'b0},
    '{ctb_pkg::OP_STOP,  4'd0,  16'h0000, 1'b0, 1'b0, 1'b0},
    '{ctb_pkg::OP_QUERY, 4'd0,  16'h0000, 1'b0, 1'b0, 1'b0},
    '{ctb_pkg::OP_TICK,  4'd15, 16'hAAAA, 1'b0, 1'b0, 1'b0},
    '{ctb_pkg::OP_START, 4'd10, 16'h5555, 1'b0, 1'b0, 1'b0},
    '{ctb_pkg::OP_QUERY, 4'd10, 16'h0000, 1'b0, 1'b0, 1'b0}
  };

  countdown_timer_bank_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // apply one operation to the model state and return its flags
  function automatic tmr_flags_t apply_timer_op(ctb_pkg::op_t m,
                                                logic [ctb_pkg::ID_W-1:0] id,
                                                logic [ctb_pkg::TICKS_W-1:0] tk);
    tmr_flags_t r;
    bit         found;
    bit         in_bank;
    r.success = 1'b1;
    r.elapsed = 1'b0;
    found     = 1'b0;
    in_bank   = int'(id) < ctb_pkg::NUM_TIMERS;
    case (m)
      ctb_pkg::OP_TICK: begin
        // slot order matters when one timer holds several slots
        for (int s = 0; s < ctb_pkg::NUM_SLOTS; s++) begin
          if (slot_busy[s] && int'(slot_tmr[s]) < ctb_pkg::NUM_TIMERS) begin
            run_count[slot_tmr[s]] = run_count[slot_tmr[s]] -
                                     ctb_pkg::COUNT_WIDTH'(1);
            if (run_count[slot_tmr[s]] == '0) slot_busy[s] = 1'b0;
          end
        end
      end
      ctb_pkg::OP_START: begin
        if (!in_bank) begin
          r.success = 1'b0;
        end else if (run_count[id] != '0) begin
          // restart: reload only, no slot search
          run_count[id] = tk[ctb_pkg::COUNT_WIDTH-1:0];
        end else begin
          run_count[id] = tk[ctb_pkg::COUNT_WIDTH-1:0];
          for (int s = 0; s < ctb_pkg::NUM_SLOTS; s++) begin
            if (!found && !slot_busy[s]) begin
              slot_busy[s] = 1'b1;
              slot_tmr[s]  = id;
              found        = 1'b1;
            end
          end
          r.success = found;
        end
      end
      ctb_pkg::OP_STOP: begin
        if (in_bank) begin
          for (int s = 0; s < ctb_pkg::NUM_SLOTS; s++) begin
            if (!found && slot_busy[s] && slot_tmr[s] == id) begin
              slot_busy[s]  = 1'b0;
              run_count[id] = '0;
              found         = 1'b1;
            end
          end
        end
        r.success = found;
      end
      default: begin
        r.elapsed = in_bank ? (run_count[id] == '0) : 1'b1;
      end
    endcase
    return r;
  endfunction

  // offer one operation, wait for the transfer, record what it should return
  task automatic push_op(ctb_pkg::op_t m, logic [ctb_pkg::ID_W-1:0] id,
                         logic [ctb_pkg::TICKS_W-1:0] tk,
                         bit typed = 1'b0, tmr_flags_t typed_flags = '0);
    tmr_flags_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= {4'b0000, tk, id};
    do @(posedge clk); while (!in_tready);
    want = apply_timer_op(m, id, tk);
    if (typed) want = typed_flags;
    flags_due.push_back(want);
    op_cnt[m]++;
    if (m == ctb_pkg::OP_START && !want.success) start_fails++;
    if (m == ctb_pkg::OP_QUERY && want.elapsed) elapsed_hits++;
  endtask

  // sender pause: stop offering until the block has returned everything
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (flags_due.size() != 0);
  endtask

  // random operation, biased toward a few timers and short counts
  task automatic pick_op(output ctb_pkg::op_t m,
                         output logic [ctb_pkg::ID_W-1:0] id,
                         output logic [ctb_pkg::TICKS_W-1:0] tk);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35)      m = ctb_pkg::OP_TICK;
    else if (r < 62) m = ctb_pkg::OP_START;
    else if (r < 77) m = ctb_pkg::OP_STOP;
    else             m = ctb_pkg::OP_QUERY;
    id = ($urandom_range(99) < 70) ? ctb_pkg::ID_W'($urandom_range(5))
                                   : ctb_pkg::ID_W'($urandom_range(15));
    r = $urandom_range(99);
    if (r < 55)      tk = ctb_pkg::TICKS_W'($urandom_range(12, 1));
    else if (r < 70) tk = '0;
    else if (r < 82) tk = 16'hFFF0 | ctb_pkg::TICKS_W'($urandom_range(15));
    else             tk = ctb_pkg::TICKS_W'($urandom);
  endtask

  task automatic note_fail(string what, logic want, logic got);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0b, got %0b", $realtime, what, want, got);
  endtask

  // receiver: random tready, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    tmr_flags_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (flags_due.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("%0t: result transfer with nothing pending, data %02h",
                   $realtime, out_tdata);
      end else begin
        want = flags_due.pop_front();
        checked_cnt++;
        if (out_tdata[0] !== want.success) note_fail("success", want.success, out_tdata[0]);
        if (out_tdata[1] !== want.elapsed) note_fail("elapsed", want.elapsed, out_tdata[1]);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, flags_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    ctb_pkg::op_t                m;
    logic [ctb_pkg::ID_W-1:0]    id;
    logic [ctb_pkg::TICKS_W-1:0] tk;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, slow sender and busy receiver
    foreach (dir_rows[i])
      push_op(dir_rows[i].op, dir_rows[i].id, dir_rows[i].tk, dir_rows[i].typed,
              '{elapsed: dir_rows[i].elapsed, success: dir_rows[i].success});
    drain_results();

    // random phase one, with a long receiver hold-off partway through
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == 200) hold_req = 1'b1;
      pick_op(m, id, tk);
      push_op(m, id, tk);
    end
    drain_results();

    // phase two, sides swapped, with a mid-phase drain
    send_idle_pct = 52;
    recv_idle_pct = 30;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == PHASE_ITEMS / 2) drain_results();
      pick_op(m, id, tk);
      push_op(m, id, tk);
    end
    drain_results();

    // phase three, back to back
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      pick_op(m, id, tk);
      push_op(m, id, tk);
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("checked %0d results: %0d ticks, %0d starts, %0d stops, %0d queries",
             checked_cnt, op_cnt[ctb_pkg::OP_TICK], op_cnt[ctb_pkg::OP_START],
             op_cnt[ctb_pkg::OP_STOP], op_cnt[ctb_pkg::OP_QUERY]);
    $display("starts refused for a full table: %0d, queries seeing an expired timer: %0d",
             start_fails, elapsed_hits);
    if (fail_cnt == 0 && flags_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ countdown_timer_bank_top.f @@
rtl/ctb_pkg.sv
rtl/countdown_timer_bank_top.sv
test/tb_top.sv
